FILE: rtl/core/rri_pkg.sv
`default_nettype none

package rri_pkg;

    // coordinate word: signed fixed point, fraction position does not matter here
    localparam int CW = 21;
    // difference of two coordinates
    localparam int DW = CW + 1;
    // normal component: product of two differences
    localparam int NW = 2 * DW;
    // normal times a difference
    localparam int PRW = NW + DW;
    // sum of three such products (plane numerator and denominator)
    localparam int SW = PRW + 2;
    // split of the numerator for the scaling multiply
    localparam int MLO = SW / 2;
    localparam int MHI = SW - MLO;
    // numerator magnitude times direction magnitude
    localparam int PW = SW + CW;
    // quotient bits kept; anything larger clamps
    localparam int QW = CW + 2;
    // edge vector and point offset widths for the inside tests
    localparam int EDW = CW + 2;
    localparam int RLW = CW + 3;
    localparam int EPW = EDW + RLW;
    localparam int ESW = EPW + 2;

    // configuration port
    localparam int CFG_W = 3 * CW;
    localparam int IDX_W = 2;
    localparam logic [IDX_W-1:0] REG_CORNER_A = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_CORNER_B = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_CORNER_C = IDX_W'(2);

    // stream widths, padded to whole bytes
    localparam int IN_FW = 6 * CW;
    localparam int IN_TW = ((IN_FW + 7) / 8) * 8;
    localparam int OUT_FW = 1 + 3 * CW + 3 * NW;
    localparam int OUT_TW = ((OUT_FW + 7) / 8) * 8;

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [NW-1:0] norm_t;

    typedef struct {
        coord_t o [3];
        coord_t v [3];
    } ray_t;

    typedef struct {
        coord_t           o [3];
        coord_t           v [3];
        logic             plane;
        logic [SW-1:0]    num_mag;
        logic [SW-1:0]    den_mag;
    } plane_t;

    typedef struct {
        logic   plane;
        coord_t p [3];
    } point_t;

    typedef struct {
        logic   impact;
        coord_t p [3];
    } result_t;

endpackage

`default_nettype wire

FILE: rtl/core/rri_plane.sv
`default_nettype none

module rri_plane
    import rri_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  coord_t corner_a [3],
    input  norm_t  nrm [3],
    input  logic   in_valid,
    output logic   in_ready,
    input  ray_t   in_word,
    output logic   out_valid,
    input  logic   out_ready,
    output plane_t out_word
);

    localparam int NST = 5;

    logic                  vld_reg [NST];
    logic                  en [NST];
    ray_t                  r0_reg;
    ray_t                  r1_reg;
    ray_t                  r2_reg;
    ray_t                  r3_reg;
    logic signed [DW-1:0]  ao_reg [3];
    logic signed [PRW-1:0] pv_reg [3];
    logic signed [PRW-1:0] pa_reg [3];
    logic signed [SW-1:0]  den_reg;
    logic signed [SW-1:0]  num_reg;
    plane_t                out_reg;

    // a stage moves when it is empty or the one after it moves
    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // input word, corner offset, products, sums, sign and magnitude
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r0_reg <= in_word;
        end
        if (en[1])
        begin
            r1_reg <= r0_reg;
            for (int i = 0; i < 3; i++)
            begin
                ao_reg[i] <= DW'(corner_a[i]) - DW'(r0_reg.o[i]);
            end
        end
        if (en[2])
        begin
            r2_reg <= r1_reg;
            for (int i = 0; i < 3; i++)
            begin
                pv_reg[i] <= PRW'(nrm[i]) * PRW'(r1_reg.v[i]);
                pa_reg[i] <= PRW'(nrm[i]) * PRW'(ao_reg[i]);
            end
        end
        if (en[3])
        begin
            r3_reg  <= r2_reg;
            den_reg <= SW'(pv_reg[0]) + SW'(pv_reg[1]) + SW'(pv_reg[2]);
            num_reg <= SW'(pa_reg[0]) + SW'(pa_reg[1]) + SW'(pa_reg[2]);
        end
        if (en[4])
        begin
            out_reg.o       <= r3_reg.o;
            out_reg.v       <= r3_reg.v;
            // plane ahead only when t is strictly positive
            out_reg.plane   <= (den_reg != '0) && (num_reg != '0)
                               && (den_reg[SW-1] == num_reg[SW-1]);
            out_reg.den_mag <= den_reg[SW-1] ? -den_reg : den_reg;
            out_reg.num_mag <= num_reg[SW-1] ? -num_reg : num_reg;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NST-1];
    assign out_word  = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rri_div.sv
`default_nettype none

module rri_div
    import rri_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  plane_t in_word,
    output logic   out_valid,
    input  logic   out_ready,
    output point_t out_word
);

    // multiply, combine, overflow check, one stage per quotient bit, fix-up
    localparam int NST = QW + 4;
    localparam int FST = NST - 1;
    localparam int XW  = CW + 3;
    localparam logic [QW-1:0] CAP = QW'(1) << (CW + 1);
    localparam logic signed [XW-1:0] HI_LIM = XW'(2 ** (CW - 1) - 1);
    localparam logic signed [XW-1:0] LO_LIM = XW'(-(2 ** (CW - 1)));

    typedef struct {
        coord_t        o [3];
        logic          vneg [3];
        logic          ovf [3];
        logic          plane;
        logic [SW-1:0] den;
    } ctx_t;

    logic                  vld_reg [NST];
    logic                  en [NST];
    ctx_t                  ctx_reg [NST-1];
    logic [MLO+CW-1:0]     plo_reg [3];
    logic [MHI+CW-1:0]     phi_reg [3];
    logic [PW-1:0]         prod_reg [3];
    logic [SW-1:0]         rem_reg [QW][3];
    logic [QW-1:0]         low_reg [QW][3];
    logic [QW-1:0]         q_reg [QW][3];
    logic [QW-1:0]         qin [QW][3];
    logic [SW:0]           trial [QW][3];
    logic [SW:0]           diff [QW][3];
    logic                  ge [QW][3];
    logic [CW-1:0]         vmag [3];
    logic [PW-QW-1:0]      ptop [3];
    logic [QW-1:0]         qm [3];
    logic signed [XW-1:0]  qs [3];
    logic signed [XW-1:0]  sum [3];
    logic signed [XW-1:0]  sat [3];
    point_t                out_reg;

    always_comb
    begin
        en[NST-1] = !vld_reg[NST-1] || out_ready;
        for (int k = NST - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NST; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            for (int k = 1; k < NST; k++)
            begin
                if (en[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // per-axis combinational pieces
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            vmag[i] = in_word.v[i][CW-1] ? CW'(-in_word.v[i]) : CW'(in_word.v[i]);
            ptop[i] = prod_reg[i][PW-1:QW];
            qin[0][i] = '0;
            for (int s = 1; s < QW; s++)
            begin
                qin[s][i] = q_reg[s-1][i];
            end
            // restoring step: remainder stays below the divisor unless the overflow check fired
            for (int s = 0; s < QW; s++)
            begin
                trial[s][i] = {rem_reg[s][i], low_reg[s][i][QW-1]};
                diff[s][i]  = trial[s][i] - {1'b0, ctx_reg[2+s].den};
                ge[s][i]    = !diff[s][i][SW];
            end
            // clamp, apply sign, add origin, saturate
            qm[i]  = (ctx_reg[FST-1].ovf[i] || (q_reg[QW-1][i] > CAP)) ? CAP : q_reg[QW-1][i];
            qs[i]  = signed'(XW'(qm[i]));
            sum[i] = XW'(ctx_reg[FST-1].o[i]) + (ctx_reg[FST-1].vneg[i] ? -qs[i] : qs[i]);
            if (sum[i] > HI_LIM)
            begin
                sat[i] = HI_LIM;
            end
            else if (sum[i] < LO_LIM)
            begin
                sat[i] = LO_LIM;
            end
            else
            begin
                sat[i] = sum[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // partial products of the numerator and the direction magnitude
        if (en[0])
        begin
            ctx_reg[0].o     <= in_word.o;
            ctx_reg[0].plane <= in_word.plane;
            ctx_reg[0].den   <= in_word.den_mag;
            for (int i = 0; i < 3; i++)
            begin
                ctx_reg[0].vneg[i] <= in_word.v[i][CW-1];
                ctx_reg[0].ovf[i]  <= 1'b0;
                plo_reg[i] <= (MLO+CW)'(in_word.num_mag[MLO-1:0]) * (MLO+CW)'(vmag[i]);
                phi_reg[i] <= (MHI+CW)'(in_word.num_mag[SW-1:MLO]) * (MHI+CW)'(vmag[i]);
            end
        end
        // full dividend
        if (en[1])
        begin
            ctx_reg[1] <= ctx_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= (PW'(phi_reg[i]) << MLO) + PW'(plo_reg[i]);
            end
        end
        // quotient too large for the kept bits, and division start
        if (en[2])
        begin
            ctx_reg[2].o     <= ctx_reg[1].o;
            ctx_reg[2].vneg  <= ctx_reg[1].vneg;
            ctx_reg[2].plane <= ctx_reg[1].plane;
            ctx_reg[2].den   <= ctx_reg[1].den;
            for (int i = 0; i < 3; i++)
            begin
                ctx_reg[2].ovf[i] <= (SW'(ptop[i]) >= ctx_reg[1].den);
                rem_reg[0][i]     <= SW'(ptop[i]);
                low_reg[0][i]     <= prod_reg[i][QW-1:0];
            end
        end
        // one quotient bit per stage
        for (int s = 0; s < QW; s++)
        begin
            if (en[3+s])
            begin
                ctx_reg[3+s] <= ctx_reg[2+s];
                for (int i = 0; i < 3; i++)
                begin
                    q_reg[s][i] <= {qin[s][i][QW-2:0], ge[s][i]};
                end
            end
        end
        for (int s = 0; s < QW - 1; s++)
        begin
            if (en[3+s])
            begin
                for (int i = 0; i < 3; i++)
                begin
                    rem_reg[s+1][i] <= ge[s][i] ? diff[s][i][SW-1:0] : trial[s][i][SW-1:0];
                    low_reg[s+1][i] <= low_reg[s][i] << 1;
                end
            end
        end
        // hit point on the plane
        if (en[FST])
        begin
            out_reg.plane <= ctx_reg[FST-1].plane;
            for (int i = 0; i < 3; i++)
            begin
                out_reg.p[i] <= ctx_reg[FST-1].plane ? CW'(sat[i]) : '0;
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[NST-1];
    assign out_word  = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/rri_edge.sv
`default_nettype none

module rri_edge
    import rri_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  coord_t  corner_a [3],
    input  coord_t  corner_b [3],
    input  coord_t  corner_c [3],
    input  logic    in_valid,
    output logic    in_ready,
    input  point_t  in_word,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_word
);

    localparam int NST = 2;

    logic                  vld_reg [NST];
    logic                  en [NST];
    logic signed [EDW-1:0] d4 [3];
    logic signed [EDW-1:0] ed [4][3];
    logic signed [RLW-1:0] rel [4][3];
    logic signed [EPW-1:0] prd_reg [4][3];
    logic signed [ESW-1:0] dsum [4];
    logic                  plane_reg;
    coord_t                p_reg [3];
    logic                  in_rect;
    result_t               out_reg;

    always_comb
    begin
        en[1] = !vld_reg[1] || out_ready;
        en[0] = !vld_reg[0] || en[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
            vld_reg[1] <= 1'b0;
        end
        else
        begin
            if (en[0])
            begin
                vld_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                vld_reg[1] <= vld_reg[0];
            end
        end
    end

    // edges a->b, b->c, c->d, d->a and the point relative to each start
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            d4[i]     = EDW'(corner_c[i]) + EDW'(corner_a[i]) - EDW'(corner_b[i]);
            ed[0][i]  = EDW'(corner_b[i]) - EDW'(corner_a[i]);
            ed[1][i]  = EDW'(corner_c[i]) - EDW'(corner_b[i]);
            ed[2][i]  = EDW'(corner_a[i]) - EDW'(corner_b[i]);
            ed[3][i]  = EDW'(corner_b[i]) - EDW'(corner_c[i]);
            rel[0][i] = RLW'(in_word.p[i]) - RLW'(corner_a[i]);
            rel[1][i] = RLW'(in_word.p[i]) - RLW'(corner_b[i]);
            rel[2][i] = RLW'(in_word.p[i]) - RLW'(corner_c[i]);
            rel[3][i] = RLW'(in_word.p[i]) - RLW'(d4[i]);
        end
        in_rect = 1'b1;
        for (int t = 0; t < 4; t++)
        begin
            dsum[t] = ESW'(prd_reg[t][0]) + ESW'(prd_reg[t][1]) + ESW'(prd_reg[t][2]);
            if (dsum[t][ESW-1])
            begin
                in_rect = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            plane_reg <= in_word.plane;
            p_reg     <= in_word.p;
            for (int t = 0; t < 4; t++)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    prd_reg[t][i] <= EPW'(ed[t][i]) * EPW'(rel[t][i]);
                end
            end
        end
        if (en[1])
        begin
            out_reg.impact <= plane_reg && in_rect;
            out_reg.p      <= p_reg;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[1];
    assign out_word  = out_reg;

endmodule

`default_nettype wire

FILE: rtl/core/ray_rectangle_intersect.sv
// Ray / rectangle intersection, one ray word per clock cycle sustained while m_tready is held high.
// 34 register stages from s_tdata to m_tvalid; the quotient unit (one bit a stage) sets the depth.
// Stalls squeeze bubbles stage by stage; nothing is lost or repeated.
// Reset clears all valid bits and the corners (normal reads zero); a corner write
// is seen by every ray accepted from the next cycle on.
`default_nettype none

module ray_rectangle_intersect
    import rri_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    input  logic              s_tvalid,
    output logic              s_tready,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, zero pad
    input  logic [IN_TW-1:0]  s_tdata,
    output logic              m_tvalid,
    input  logic              m_tready,
    // impact, point_x, point_y, point_z, normal_x, normal_y, normal_z, zero pad
    output logic [OUT_TW-1:0] m_tdata
);

    localparam int PAD_O = OUT_TW - OUT_FW;

    coord_t               corner_reg [3][3];
    logic signed [DW-1:0] e1 [3];
    logic signed [DW-1:0] e2 [3];
    norm_t                xp_reg [6];
    norm_t                n_reg [3];
    norm_t                nsel [3];
    ray_t                 ray_in;
    logic                 pl_valid;
    logic                 pl_ready;
    plane_t               pl_word;
    logic                 dv_valid;
    logic                 dv_ready;
    point_t               dv_word;
    result_t              res;

    // corner registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    corner_reg[r][k] <= '0;
                end
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CORNER_A:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        corner_reg[0][k] <= cfg_data[k*CW +: CW];
                    end
                end
                REG_CORNER_B:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        corner_reg[1][k] <= cfg_data[k*CW +: CW];
                    end
                end
                REG_CORNER_C:
                begin
                    for (int k = 0; k < 3; k++)
                    begin
                        corner_reg[2][k] <= cfg_data[k*CW +: CW];
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // normal = (c - a) x (b - a), products then differences
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            e1[k] = DW'(corner_reg[2][k]) - DW'(corner_reg[0][k]);
            e2[k] = DW'(corner_reg[1][k]) - DW'(corner_reg[0][k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 6; k++)
            begin
                xp_reg[k] <= '0;
            end
            for (int k = 0; k < 3; k++)
            begin
                n_reg[k] <= '0;
            end
        end
        else
        begin
            xp_reg[0] <= NW'(e1[1]) * NW'(e2[2]);
            xp_reg[1] <= NW'(e1[2]) * NW'(e2[1]);
            xp_reg[2] <= NW'(e1[2]) * NW'(e2[0]);
            xp_reg[3] <= NW'(e1[0]) * NW'(e2[2]);
            xp_reg[4] <= NW'(e1[0]) * NW'(e2[1]);
            xp_reg[5] <= NW'(e1[1]) * NW'(e2[0]);
            n_reg[0]  <= xp_reg[0] - xp_reg[1];
            n_reg[1]  <= xp_reg[2] - xp_reg[3];
            n_reg[2]  <= xp_reg[4] - xp_reg[5];
        end
    end

    // unpack the input word
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            ray_in.o[k] = s_tdata[k*CW +: CW];
            ray_in.v[k] = s_tdata[(3+k)*CW +: CW];
        end
    end

    rri_plane u_plane (
        .clk       (clk),
        .rst_n     (rst_n),
        .corner_a  (corner_reg[0]),
        .nrm       (n_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_word   (ray_in),
        .out_valid (pl_valid),
        .out_ready (pl_ready),
        .out_word  (pl_word)
    );

    rri_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pl_valid),
        .in_ready  (pl_ready),
        .in_word   (pl_word),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .out_word  (dv_word)
    );

    rri_edge u_edge (
        .clk       (clk),
        .rst_n     (rst_n),
        .corner_a  (corner_reg[0]),
        .corner_b  (corner_reg[1]),
        .corner_c  (corner_reg[2]),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .in_word   (dv_word),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_word  (res)
    );

    // pack the result word; normal only reported on impact
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            nsel[k] = res.impact ? n_reg[k] : '0;
        end
    end

    assign m_tdata = {{PAD_O{1'b0}}, nsel[2], nsel[1], nsel[0],
                      res.p[2], res.p[1], res.p[0], res.impact};

endmodule

`default_nettype wire
